// ===== hw/rtl/kfrc_pkg.sv =====
package kfrc_pkg;

  // Cache geometry.
  localparam int ENTRIES       = 16;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int IDX_W         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KEY_W         = 19;

  // Item actions.
  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  // Input item.
  typedef struct packed {
    logic        action;
    logic [10:0] species;
    logic [7:0]  form;
    logic [31:0] payload;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic        hit;
    logic [3:0]  hit_index;
    logic [31:0] payload_out;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_SELECT,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic capture_match;
    logic capture_select;
    logic deliver;
  } cmd_t;

endpackage

// ===== hw/rtl/kfrc_ram.sv =====
module kfrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/kfrc_ctrl.sv =====
module kfrc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output kfrc_pkg::cmd_t     cmd
);

  kfrc_pkg::state_t state;
  kfrc_pkg::state_t state_next;
  logic             out_free;

  // The output register can take a new item when it is empty or being drained.
  assign out_free = !out_valid || out_ready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      kfrc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = kfrc_pkg::S_COMPARE;
        end
      end
      kfrc_pkg::S_COMPARE: state_next = kfrc_pkg::S_SELECT;
      kfrc_pkg::S_SELECT:  state_next = kfrc_pkg::S_DONE;
      kfrc_pkg::S_DONE: begin
        if (out_free) begin
          state_next = kfrc_pkg::S_IDLE;
        end
      end
      default: state_next = kfrc_pkg::S_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      kfrc_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      kfrc_pkg::S_COMPARE: cmd.capture_match  = 1'b1;
      kfrc_pkg::S_SELECT:  cmd.capture_select = 1'b1;
      kfrc_pkg::S_DONE:    cmd.deliver        = out_free;
      default: cmd = '0;
    endcase
  end

  // State register and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kfrc_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.deliver) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/kfrc_dpath.sv =====
module kfrc_dpath (
  input  logic                clk,
  input  logic                rst,
  input  kfrc_pkg::cmd_t      cmd,
  input  kfrc_pkg::in_item_t  in_data,
  output kfrc_pkg::out_item_t out_data
);

  kfrc_pkg::in_item_t                 item;
  logic [kfrc_pkg::KEY_W-1:0]         item_key;
  logic [kfrc_pkg::KEY_W-1:0]         keys [kfrc_pkg::ENTRIES];
  logic [kfrc_pkg::ENTRIES-1:0]       valid;
  logic [kfrc_pkg::ENTRIES-1:0]       match;
  logic [kfrc_pkg::ENTRIES-1:0]       match_next;
  logic [kfrc_pkg::IDX_W-1:0]         ptr;
  logic [kfrc_pkg::IDX_W-1:0]         enc_idx;
  logic                               enc_hit;
  logic [kfrc_pkg::IDX_W-1:0]         sel_idx;
  logic                               sel_hit;
  logic [kfrc_pkg::PAYLOAD_WIDTH-1:0] rd_payload;
  logic                               do_write;

  assign item_key = {item.species, item.form};

  // Key compare against every valid entry.
  always_comb begin
    for (int i = 0; i < kfrc_pkg::ENTRIES; i++) begin
      match_next[i] = valid[i] && (keys[i] == item_key);
    end
  end

  // Priority encoder: the lowest matching entry wins.
  always_comb begin
    enc_idx = '0;
    enc_hit = 1'b0;
    for (int i = kfrc_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        enc_idx = kfrc_pkg::IDX_W'(i);
        enc_hit = 1'b1;
      end
    end
  end

  // A miss on an insert allocates the entry under the insert pointer.
  assign do_write = cmd.deliver && (item.action == kfrc_pkg::ACT_INSERT) && !sel_hit;

  kfrc_ram #(
    .WIDTH(kfrc_pkg::PAYLOAD_WIDTH),
    .DEPTH(kfrc_pkg::ENTRIES)
  ) u_payload_ram (
    .clk  (clk),
    .we   (do_write),
    .waddr(ptr),
    .wdata(kfrc_pkg::PAYLOAD_WIDTH'(item.payload)),
    .raddr(enc_idx),
    .rdata(rd_payload)
  );

  // Item, match and select pipeline registers plus the result register.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
    if (cmd.capture_match) begin
      match <= match_next;
    end
    if (cmd.capture_select) begin
      sel_idx <= enc_idx;
      sel_hit <= enc_hit;
    end
    if (cmd.deliver) begin
      out_data.hit       <= sel_hit;
      out_data.hit_index <= sel_hit ? 4'(sel_idx) : 4'd0;
      out_data.payload_out <= (sel_hit && (item.action == kfrc_pkg::ACT_LOOKUP))
                              ? 32'(rd_payload) : 32'd0;
    end
    if (do_write) begin
      keys[ptr] <= item_key;
    end
  end

  // Valid bits and the round-robin insert pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      ptr   <= '0;
    end else if (do_write) begin
      valid[ptr] <= 1'b1;
      if (ptr == kfrc_pkg::IDX_W'(kfrc_pkg::ENTRIES - 1)) begin
        ptr <= '0;
      end else begin
        ptr <= ptr + 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/keyed_fifo_replacement_cache.sv =====
// Fully associative cache of 16 payload words keyed by (species, form), with
// round-robin replacement. A lookup item returns hit, the lowest matching
// entry index and its payload; an insert item returns the hit and index of
// the search it made and, on a miss, writes key and payload at the insert
// pointer. The item is latched at the edge that accepts it, and its result
// then passes in order through the parallel key compare, the priority encode
// with the payload RAM read, and the result register load. The next item is
// accepted in the cycle after the result is loaded, even while that result
// still waits to be taken; the cache works on one item at a time. While a
// result waits, the following item runs up to the result stage and holds
// there, and the input stays stalled until the waiting result is taken.
// Reset clears all valid bits and the insert pointer.
module keyed_fifo_replacement_cache (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  kfrc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kfrc_pkg::out_item_t out_data
);

  kfrc_pkg::cmd_t cmd;

  // Sequencing of one item at a time.
  kfrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  // Key store, compare, payload store and result register.
  kfrc_dpath u_dpath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .in_data (in_data),
    .out_data(out_data)
  );

endmodule
